### rtl/flt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FFT low-pass truncation package
// Shared widths, payload structs, job descriptor and engine state encoding.
// ----------------------------------------------------------------------------
package flt_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int VALUE_WIDTH    = 18;
  localparam int CUTOFF_WIDTH   = 7;
  localparam int MAX_POINTS_DEF = 64;
  localparam int CNT_MAX_W      = 13;
  localparam int CFG_ADDR_W     = 3;

  localparam logic [CUTOFF_WIDTH-1:0] CUTOFF_RESET = 7'd64;

  // Register index codes (paddr[2])
  localparam logic REG_CUTOFF = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last_res;
    logic                          overflowed;
  } out_item_t;

  // One loaded block handed from loader to engine
  typedef struct packed {
    logic [CNT_MAX_W-1:0] count;
    logic                 ovf;
  } job_t;

  // Engine status toward loader side
  typedef struct packed {
    logic loading;
    logic pop;
  } bk_status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD_RD,
    BK_LOAD_WR,
    BK_BF_RD,
    BK_BF_M1,
    BK_BF_M2,
    BK_BF_T,
    BK_BF_WP,
    BK_BF_WQ,
    BK_PERM_RD,
    BK_PERM_WR,
    BK_OUT_RD,
    BK_OUT_WR
  } bk_state_t;

endpackage

### rtl/flt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FFT low-pass loader
// Takes samples into the point buffer, counts them, flags dropped samples and
// hands a job descriptor to the queue when the final sample arrives.
// ----------------------------------------------------------------------------
module flt_front #(
  parameter int MAX_POINTS = flt_pkg::MAX_POINTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_accept,
  input  flt_pkg::in_item_t                       in_data,
  input  logic [$clog2(MAX_POINTS)-1:0]           pt_raddr,
  output logic signed [flt_pkg::SAMPLE_WIDTH-1:0] pt_rdata,
  output logic                                    job_push,
  output flt_pkg::job_t                           job_data
);
  import flt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  logic signed [SAMPLE_WIDTH-1:0] pt_mem [MAX_POINTS];
  logic signed [SAMPLE_WIDTH-1:0] pt_rdata_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             room;
  logic [CNT_W-1:0] count_inc;
  logic             ovf_inc;

  assign room      = (count_r < CNT_W'(MAX_POINTS));
  assign count_inc = room ? count_r + CNT_W'(1) : count_r;
  assign ovf_inc   = ovf_r | ~room;

  // Advance count, close the block on last
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    job_push  = 1'b0;
    job_data  = '{count: CNT_MAX_W'(count_inc), ovf: ovf_inc};
    if (in_accept) begin
      if (in_data.last) begin
        job_push  = 1'b1;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_inc;
        ovf_nxt   = ovf_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Point buffer: write on transfer while there is room, registered read
  always_ff @(posedge clk) begin
    if (in_accept && room) begin
      pt_mem[count_r[ADDR_W-1:0]] <= in_data.sample;
    end
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  assign pt_rdata = pt_rdata_r;

endmodule

### rtl/flt_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FFT low-pass job queue
// Single-slot queue holding one finished block descriptor for the engine.
// ----------------------------------------------------------------------------
module flt_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  flt_pkg::job_t push_data,
  input  logic          pop,
  output logic          valid,
  output flt_pkg::job_t head
);
  import flt_pkg::*;

  logic valid_r, valid_nxt;
  job_t head_r;

  // Fill on push, drain on pop
  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b0;
    end
    if (push) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      head_r <= push_data;
    end
  end

  assign valid = valid_r;
  assign head  = head_r;

endmodule

### rtl/flt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FFT low-pass engine
// Copies a block bit-reversed into work memory, runs the forward FFT, clears
// high bins during the bit-reversed copy into the second bank, runs the
// halving inverse FFT and emits the truncated real parts.
// ----------------------------------------------------------------------------
module flt_back #(
  parameter int MAX_POINTS = flt_pkg::MAX_POINTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    job_valid,
  input  flt_pkg::job_t                           job,
  input  logic [flt_pkg::CUTOFF_WIDTH-1:0]        cutoff,
  output logic [$clog2(MAX_POINTS)-1:0]           pt_raddr,
  input  logic signed [flt_pkg::SAMPLE_WIDTH-1:0] pt_rdata,
  output flt_pkg::bk_status_t                     status,
  output logic                                    out_valid,
  output flt_pkg::out_item_t                      out_data
);
  import flt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int LG_W   = $clog2(ADDR_W + 1);
  localparam int NPOW   = 1 << ADDR_W;
  localparam int HALF   = NPOW / 2;
  localparam int TW_W   = (ADDR_W > 1) ? ADDR_W - 1 : 1;
  localparam int TW_E   = 34;
  localparam longint unsigned TwoPiQ30 = 64'd6746518852;
  localparam longint          PiQ30    = 64'sd3373259426;

  // Q30 to Q15 with round to nearest and saturation
  function automatic longint q15(longint v);
    longint q;
    q = (v + 64'sd16384) >>> 15;
    if (q > 64'sd32767)  q = 64'sd32767;
    if (q < -64'sd32768) q = -64'sd32768;
    return q;
  endfunction

  // Quotient of two nonnegative constants by shift and subtract
  function automatic longint cquot(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((n >>> b) & 64'sd1);
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // Twiddle for index j of an NPOW-point stage: {cos with quadrant fold, sin}
  function automatic logic [TW_E-1:0] tw_entry(int j);
    longint           a;
    longint unsigned  au;
    longint           x2;
    longint           tc;
    longint           ts;
    longint           sc;
    longint           ss;
    longint           cq;
    longint           sq;
    logic             flip;
    logic [16:0]      wr17;
    logic [16:0]      s17;
    a    = longint'((TwoPiQ30 * longint'(j)) >> ADDR_W);
    flip = (4 * j > NPOW);
    if (flip) a = PiQ30 - a;
    au = longint'(a);
    x2 = longint'((au * au) >> 30);
    tc = 64'sd1 << 30;
    ts = a;
    sc = 0;
    ss = 0;
    for (int i = 0; i < 14; i++) begin
      sc = ((i & 1) != 0) ? sc - tc : sc + tc;
      ss = ((i & 1) != 0) ? ss - ts : ss + ts;
      tc = cquot((tc * x2) >>> 30, longint'((2 * i + 1) * (2 * i + 2)));
      ts = cquot((ts * x2) >>> 30, longint'((2 * i + 2) * (2 * i + 3)));
    end
    cq   = q15(sc);
    sq   = q15(ss);
    wr17 = flip ? 17'(-cq) : 17'(cq);
    s17  = 17'(sq);
    return {wr17, s17};
  endfunction

  function automatic logic [HALF*TW_E-1:0] tw_build();
    logic [HALF*TW_E-1:0] rom;
    rom = '0;
    for (int j = 0; j < HALF; j++) begin
      rom[j*TW_E +: TW_E] = tw_entry(j);
    end
    return rom;
  endfunction

  localparam logic [HALF*TW_E-1:0] TW_ROM = tw_build();

  function automatic logic signed [31:0] sat32(logic signed [50:0] v);
    if (v > 51'sd2147483647)  return 32'sh7FFFFFFF;
    if (v < -51'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Butterfly leg: x +/- t, halved with rounding on the inverse pass
  function automatic logic signed [31:0] bfly(logic signed [31:0] x,
                                              logic signed [31:0] t,
                                              logic sub, logic inv);
    logic signed [50:0] s;
    s = sub ? 51'(x) - 51'(t) : 51'(x) + 51'(t);
    if (inv) s = (s + 51'sd1) >>> 1;
    return sat32(s);
  endfunction

  function automatic logic [ADDR_W-1:0] rev_full(logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[ADDR_W-1-b] = v[b];
    end
    return r;
  endfunction

  // Stages needed for m points
  function automatic logic [LG_W-1:0] lg_of(logic [CNT_W-1:0] m);
    logic [CNT_W-1:0] mm1;
    logic [LG_W-1:0]  lg;
    mm1 = m - CNT_W'(1);
    lg  = '0;
    for (int b = 0; b < ADDR_W; b++) begin
      if (mm1[b]) lg = LG_W'(b + 1);
    end
    return lg;
  endfunction

  // Work banks: A for forward, B for inverse
  logic [63:0] mem_a [NPOW];
  logic [63:0] mem_b [NPOW];
  logic [63:0] ra0_r, ra1_r, rb0_r, rb1_r;

  bk_state_t state_r, state_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] bf_r, bf_nxt;
  logic [LG_W-1:0]   stage_r, stage_nxt;
  logic [LG_W-1:0]   lgn_r, lgn_nxt;
  logic [CNT_W-1:0]  m_r, m_nxt;
  logic              ovf_r, ovf_nxt;
  logic              inv_r, inv_nxt;

  logic signed [16:0] wr_r, wi_r;
  logic signed [48:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [31:0] tr_r, ti_r;
  out_item_t          out_r;
  logic               out_valid_r, out_valid_nxt;

  logic [ADDR_W:0]    n_full;
  logic [ADDR_W-1:0]  n_m1, bf_m1;
  logic [ADDR_W-1:0]  half, kmask, kk, pp, qq, rev_i, j_full;
  logic [TW_W-1:0]    j_idx;
  logic [TW_E-1:0]    tw;
  logic [63:0]        xd, yd;
  logic signed [31:0] x_re, x_im, y_re, y_im;
  logic               i_last_n, i_last_m, bf_last, st_last, i_cut, i_in;

  logic              we_a, we_b;
  logic [ADDR_W-1:0] raddr0, raddr1, waddr;
  logic [63:0]       wdata;

  logic signed [49:0] sum_re, sum_im;
  logic signed [31:0] val32;
  logic signed [32:0] mag;
  logic signed [VALUE_WIDTH-1:0] val_sat;
  logic signed [31:0] load_re;

  // Index arithmetic
  assign n_full   = (ADDR_W + 1)'(1) << lgn_r;
  assign n_m1     = ADDR_W'(n_full - (ADDR_W + 1)'(1));
  assign bf_m1    = n_m1 >> 1;
  assign half     = ADDR_W'(1) << (stage_r - LG_W'(1));
  assign kmask    = half - ADDR_W'(1);
  assign kk       = bf_r & kmask;
  assign pp       = ((bf_r & ~kmask) << 1) | kk;
  assign qq       = pp | half;
  assign j_full   = kk << (LG_W'(ADDR_W) - stage_r);
  assign j_idx    = j_full[TW_W-1:0];
  assign tw       = TW_ROM[j_idx*TW_E +: TW_E];
  assign rev_i    = rev_full(i_r) >> (LG_W'(ADDR_W) - lgn_r);
  assign i_last_n = (i_r == n_m1);
  assign i_last_m = ({1'b0, i_r} == m_r - CNT_W'(1));
  assign i_in     = ({1'b0, i_r} < m_r);
  assign i_cut    = (32'(i_r) >= 32'(cutoff));
  assign bf_last  = (bf_r == bf_m1);
  assign st_last  = (stage_r == lgn_r);

  assign xd   = inv_r ? rb0_r : ra0_r;
  assign yd   = inv_r ? rb1_r : ra1_r;
  assign x_re = xd[31:0];
  assign x_im = xd[63:32];
  assign y_re = yd[31:0];
  assign y_im = yd[63:32];

  assign sum_re  = 50'(p0_r) - 50'(p1_r) + 50'sd16384;
  assign sum_im  = 50'(p2_r) + 50'(p3_r) + 50'sd16384;
  assign load_re = 32'(pt_rdata) <<< 8;

  // Output: truncate toward zero, saturate
  assign val32   = rb0_r[31:0];
  assign mag     = (val32 >= 0) ? (33'(val32) >>> 8) : -((-33'(val32)) >>> 8);
  assign val_sat = (mag > 33'sd131071)  ? 18'sh1FFFF :
                   (mag < -33'sd131072) ? 18'sh20000 : mag[VALUE_WIDTH-1:0];

  assign pt_raddr = i_r;
  assign raddr0   = ((state_r == BK_PERM_RD) || (state_r == BK_PERM_WR) ||
                     (state_r == BK_OUT_RD) || (state_r == BK_OUT_WR)) ? i_r : pp;
  assign raddr1   = qq;

  // Sequencer: next state and memory controls
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    bf_nxt        = bf_r;
    stage_nxt     = stage_r;
    lgn_nxt       = lgn_r;
    m_nxt         = m_r;
    ovf_nxt       = ovf_r;
    inv_nxt       = inv_r;
    out_valid_nxt = 1'b0;
    we_a          = 1'b0;
    we_b          = 1'b0;
    waddr         = rev_i;
    wdata         = '0;
    status        = '{loading: 1'b0, pop: 1'b0};
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          status.pop = 1'b1;
          m_nxt      = job.count[CNT_W-1:0];
          ovf_nxt    = job.ovf;
          lgn_nxt    = lg_of(job.count[CNT_W-1:0]);
          i_nxt      = '0;
          inv_nxt    = 1'b0;
          state_nxt  = BK_LOAD_RD;
        end
      end
      BK_LOAD_RD: begin
        status.loading = 1'b1;
        state_nxt      = BK_LOAD_WR;
      end
      BK_LOAD_WR: begin
        status.loading = 1'b1;
        we_a           = 1'b1;
        wdata          = i_in ? {32'd0, load_re} : 64'd0;
        i_nxt          = i_r + ADDR_W'(1);
        bf_nxt         = '0;
        stage_nxt      = LG_W'(1);
        if (!i_last_n) begin
          state_nxt = BK_LOAD_RD;
        end else if (lgn_r == '0) begin
          i_nxt     = '0;
          state_nxt = BK_PERM_RD;
        end else begin
          state_nxt = BK_BF_RD;
        end
      end
      BK_BF_RD: state_nxt = BK_BF_M1;
      BK_BF_M1: state_nxt = BK_BF_M2;
      BK_BF_M2: state_nxt = BK_BF_T;
      BK_BF_T:  state_nxt = BK_BF_WP;
      BK_BF_WP: begin
        we_a      = ~inv_r;
        we_b      = inv_r;
        waddr     = pp;
        wdata     = {bfly(x_im, ti_r, 1'b0, inv_r), bfly(x_re, tr_r, 1'b0, inv_r)};
        state_nxt = BK_BF_WQ;
      end
      BK_BF_WQ: begin
        we_a      = ~inv_r;
        we_b      = inv_r;
        waddr     = qq;
        wdata     = {bfly(x_im, ti_r, 1'b1, inv_r), bfly(x_re, tr_r, 1'b1, inv_r)};
        state_nxt = BK_BF_RD;
        if (!bf_last) begin
          bf_nxt = bf_r + ADDR_W'(1);
        end else if (!st_last) begin
          bf_nxt    = '0;
          stage_nxt = stage_r + LG_W'(1);
        end else begin
          i_nxt     = '0;
          state_nxt = inv_r ? BK_OUT_RD : BK_PERM_RD;
        end
      end
      BK_PERM_RD: state_nxt = BK_PERM_WR;
      BK_PERM_WR: begin
        we_b      = 1'b1;
        wdata     = i_cut ? 64'd0 : ra0_r;
        i_nxt     = i_r + ADDR_W'(1);
        bf_nxt    = '0;
        stage_nxt = LG_W'(1);
        inv_nxt   = 1'b1;
        if (!i_last_n) begin
          state_nxt = BK_PERM_RD;
        end else if (lgn_r == '0) begin
          i_nxt     = '0;
          state_nxt = BK_OUT_RD;
        end else begin
          state_nxt = BK_BF_RD;
        end
      end
      BK_OUT_RD: state_nxt = BK_OUT_WR;
      BK_OUT_WR: begin
        out_valid_nxt = 1'b1;
        i_nxt         = i_r + ADDR_W'(1);
        state_nxt     = i_last_m ? BK_IDLE : BK_OUT_RD;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Counters and block descriptor
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    bf_r    <= bf_nxt;
    stage_r <= stage_nxt;
    lgn_r   <= lgn_nxt;
    m_r     <= m_nxt;
    ovf_r   <= ovf_nxt;
    inv_r   <= inv_nxt;
  end

  // Butterfly datapath: twiddle, products, rounded twiddle product
  always_ff @(posedge clk) begin
    if (state_r == BK_BF_RD) begin
      wr_r <= tw[33:17];
      wi_r <= inv_r ? $signed(tw[16:0]) : -$signed(tw[16:0]);
    end
    if (state_r == BK_BF_M1) begin
      p0_r <= wr_r * y_re;
      p1_r <= wi_r * y_im;
    end
    if (state_r == BK_BF_M2) begin
      p2_r <= wr_r * y_im;
      p3_r <= wi_r * y_re;
    end
    if (state_r == BK_BF_T) begin
      tr_r <= sat32(51'(sum_re >>> 15));
      ti_r <= sat32(51'(sum_im >>> 15));
    end
    if (state_r == BK_OUT_WR) begin
      out_r <= '{value: val_sat, last_res: i_last_m, overflowed: ovf_r};
    end
  end

  // Work banks: one write port, two registered read ports each
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    ra0_r <= mem_a[raddr0];
    ra1_r <= mem_a[raddr1];
    rb0_r <= mem_b[raddr0];
    rb1_r <= mem_b[raddr1];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/fft_lowpass_truncate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FFT low-pass by bin truncation
// Loads a block of samples, pads to a power of two, forward FFT, clears bins
// from cutoff_bin upward, halving inverse FFT, emits truncated real parts.
//
// Channel   Direction  Handshake                 Payload
// input     in         start / busy              in_data  (sample, last)
// result    out        out_valid strobe, 1 cycle out_data (value, last_res,
//                                                          overflowed)
// config    in         APB psel/penable/pwrite   cutoff_bin at byte 0
//
// A sample transfers whenever start is high and busy is low. After the final
// sample the engine copies the block, runs two transforms of (N/2)*log2(N)
// butterflies in the shared butterfly unit, makes a clearing copy and emits
// M results. busy is high while a block waits for the engine and while the
// engine copies it; the next block then loads during the transforms. Results
// cannot be held off. Reset is synchronous; cutoff_bin resets to 64.
// ----------------------------------------------------------------------------
module fft_lowpass_truncate #(
  parameter int MAX_POINTS = flt_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  flt_pkg::in_item_t               in_data,
  output logic                            out_valid,
  output flt_pkg::out_item_t              out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [flt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import flt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);

  logic [CUTOFF_WIDTH-1:0]       cutoff_r;
  logic                          in_accept;
  logic                          cfg_write;
  logic                          job_push;
  job_t                          job_in, jq_head;
  logic                          jq_valid;
  bk_status_t                    bk_stat;
  logic [ADDR_W-1:0]             pt_raddr;
  logic signed [SAMPLE_WIDTH-1:0] pt_rdata;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CUTOFF) ? {{(32 - CUTOFF_WIDTH){1'b0}}, cutoff_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_write && (paddr[2] == REG_CUTOFF)) begin
      cutoff_r <= pwdata[CUTOFF_WIDTH-1:0];
    end
  end

  // Hold input while a block waits or is being copied
  assign busy      = jq_valid || bk_stat.loading;
  assign in_accept = start && !busy;

  flt_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_data  (in_data),
    .pt_raddr (pt_raddr),
    .pt_rdata (pt_rdata),
    .job_push (job_push),
    .job_data (job_in)
  );

  flt_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_data(job_in),
    .pop      (bk_stat.pop),
    .valid    (jq_valid),
    .head     (jq_head)
  );

  flt_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(jq_valid),
    .job      (jq_head),
    .cutoff   (cutoff_r),
    .pt_raddr (pt_raddr),
    .pt_rdata (pt_rdata),
    .status   (bk_stat),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // A queued job only appears after a final-sample transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(jq_valid) |-> $past(start && !busy && in_data.last))
    else $error("job queued without final sample");

  // The engine never pops an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> jq_valid)
    else $error("job pop from empty queue");

  // The final result of a block is not followed by another in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_res) |=> !out_valid)
    else $error("result strobe right after final result");

endmodule
